// File: design/interval_timeline_sequencer_defines.svh
// Assertion macros for the interval timeline sequencer.
`ifndef INTERVAL_TIMELINE_SEQUENCER_DEFINES_SVH
`define INTERVAL_TIMELINE_SEQUENCER_DEFINES_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define ITS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define ITS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/its_pkg.sv
`timescale 1ns / 1ps
package its_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int NUM_TRACKS  = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int TIME_W      = 32;
  localparam int SCALE_W     = 16;
  localparam int TRK_W       = 5;
  localparam int PROD_W      = TIME_W + SCALE_W;
  localparam int SUM_W       = PROD_W - 8 + 1;

  localparam logic [3:0] MODE_TICK         = 4'd0;
  localparam logic [3:0] MODE_SET_TIME     = 4'd1;
  localparam logic [3:0] MODE_START        = 4'd2;
  localparam logic [3:0] MODE_STOP         = 4'd3;
  localparam logic [3:0] MODE_PAUSE        = 4'd4;
  localparam logic [3:0] MODE_RESUME       = 4'd5;
  localparam logic [3:0] MODE_ADD          = 4'd6;
  localparam logic [3:0] MODE_REMOVE       = 4'd7;
  localparam logic [3:0] MODE_SET_START    = 4'd8;
  localparam logic [3:0] MODE_SET_END      = 4'd9;
  localparam logic [3:0] MODE_SET_TRACK    = 4'd10;
  localparam logic [3:0] MODE_ENABLE_TRACK = 4'd11;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_STOP  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic signed [SCALE_W-1:0] SCALE_RESET = 16'sd256;

  typedef struct packed {
    logic [3:0]               mode;
    logic signed [TIME_W-1:0] time_value;
    logic signed [TIME_W-1:0] end_value;
    logic [3:0]               entry_index;
    logic [TRK_W-1:0]         track_id;
    logic                     enable;
  } its_req_t;

  typedef struct packed {
    logic [1:0]               event_kind;
    logic [3:0]               event_index;
    logic [1:0]               status;
    logic signed [TIME_W-1:0] playhead;
    logic                     last;
  } its_result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MUL, S_SAT, S_SCAN, S_RESTART, S_SHIFT, S_FLUSH
  } its_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MODE, OP_MUL, OP_SAT, OP_PREP_SET, OP_PREP_STOP,
    OP_PREP_START, OP_PREP_TRACK, OP_SINGLE, OP_SCAN, OP_SHIFT, OP_FLUSH
  } its_op_t;

  typedef enum logic [2:0] {
    SCAN_MOVE, SCAN_SKIP, SCAN_START, SCAN_STOP, SCAN_TRACK
  } its_scan_t;

  typedef struct packed {
    its_op_t op;
  } its_cmd_t;

  typedef struct packed {
    logic [3:0] mode;
    logic       running;
    logic       paused;
    logic       idx_bad;
    logic       full;
    logic       time_same;
    logic       track_noop;
    logic       scan_end;
    logic       shift_end;
  } its_stat_t;

endpackage

// File: design/its_ctrl.sv
`timescale 1ns / 1ps
module its_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output its_pkg::its_cmd_t cmd,
  input  its_pkg::its_stat_t stat
);

  its_pkg::its_state_t state, state_next;
  logic again, again_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= its_pkg::S_IDLE;
      again <= 1'b0;
    end else begin
      state <= state_next;
      again <= again_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      its_pkg::S_IDLE: begin
        if (start) state_next = its_pkg::S_DECODE;
      end
      its_pkg::S_DECODE: begin
        unique case (stat.mode)
          its_pkg::MODE_TICK:
            state_next = (stat.running && !stat.paused) ? its_pkg::S_MUL : its_pkg::S_FLUSH;
          its_pkg::MODE_SET_TIME:
            state_next = (stat.running && !stat.time_same) ? its_pkg::S_SCAN
                                                           : its_pkg::S_FLUSH;
          its_pkg::MODE_START: state_next = its_pkg::S_SCAN;
          its_pkg::MODE_STOP:
            state_next = stat.running ? its_pkg::S_SCAN : its_pkg::S_FLUSH;
          its_pkg::MODE_REMOVE:
            state_next = stat.idx_bad ? its_pkg::S_FLUSH : its_pkg::S_SHIFT;
          its_pkg::MODE_ENABLE_TRACK:
            state_next = (!stat.track_noop && stat.running) ? its_pkg::S_SCAN
                                                            : its_pkg::S_FLUSH;
          default: state_next = its_pkg::S_FLUSH;
        endcase
      end
      its_pkg::S_MUL:     state_next = its_pkg::S_SAT;
      its_pkg::S_SAT:     state_next = its_pkg::S_SCAN;
      its_pkg::S_SCAN: begin
        if (stat.scan_end) state_next = again ? its_pkg::S_RESTART : its_pkg::S_FLUSH;
      end
      its_pkg::S_RESTART: state_next = its_pkg::S_SCAN;
      its_pkg::S_SHIFT: begin
        if (stat.shift_end) state_next = its_pkg::S_FLUSH;
      end
      its_pkg::S_FLUSH:   state_next = its_pkg::S_IDLE;
      default:            state_next = its_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op     = its_pkg::OP_NONE;
    again_next = again;
    busy       = (state != its_pkg::S_IDLE);
    unique case (state)
      its_pkg::S_IDLE: begin
        if (start) cmd.op = its_pkg::OP_LOAD;
        again_next = 1'b0;
      end
      its_pkg::S_DECODE: begin
        unique case (stat.mode)
          its_pkg::MODE_SET_TIME:
            if (stat.running && !stat.time_same) cmd.op = its_pkg::OP_PREP_SET;
          its_pkg::MODE_START: begin
            cmd.op     = stat.running ? its_pkg::OP_PREP_STOP : its_pkg::OP_PREP_START;
            again_next = stat.running;
          end
          its_pkg::MODE_STOP:
            if (stat.running) cmd.op = its_pkg::OP_PREP_STOP;
          its_pkg::MODE_PAUSE, its_pkg::MODE_RESUME: cmd.op = its_pkg::OP_MODE;
          its_pkg::MODE_ADD:
            if (!stat.full) cmd.op = its_pkg::OP_SINGLE;
          its_pkg::MODE_REMOVE, its_pkg::MODE_SET_START, its_pkg::MODE_SET_END,
          its_pkg::MODE_SET_TRACK:
            if (!stat.idx_bad) cmd.op = its_pkg::OP_SINGLE;
          its_pkg::MODE_ENABLE_TRACK:
            if (!stat.track_noop) cmd.op = its_pkg::OP_PREP_TRACK;
          default: cmd.op = its_pkg::OP_NONE;
        endcase
      end
      its_pkg::S_MUL:  cmd.op = its_pkg::OP_MUL;
      its_pkg::S_SAT:  cmd.op = its_pkg::OP_SAT;
      its_pkg::S_SCAN: cmd.op = its_pkg::OP_SCAN;
      its_pkg::S_RESTART: begin
        cmd.op     = its_pkg::OP_PREP_START;
        again_next = 1'b0;
      end
      its_pkg::S_SHIFT: cmd.op = its_pkg::OP_SHIFT;
      its_pkg::S_FLUSH: cmd.op = its_pkg::OP_FLUSH;
      default:          cmd.op = its_pkg::OP_NONE;
    endcase
  end

endmodule

// File: design/its_datapath.sv
`timescale 1ns / 1ps
module its_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  its_pkg::its_req_t                       req,
  input  logic                                    cfg_we,
  input  logic signed [its_pkg::SCALE_W-1:0]      cfg_data,
  input  its_pkg::its_cmd_t                       cmd,
  output its_pkg::its_stat_t                      stat,
  output logic                                    result_valid,
  output its_pkg::its_result_t                    result
);

  localparam logic signed [its_pkg::SUM_W-1:0] SAT_MAX =
    its_pkg::SUM_W'(64'sh7FFFFFFF);
  localparam logic signed [its_pkg::SUM_W-1:0] SAT_MIN =
    -its_pkg::SUM_W'(64'sh80000000);

  logic signed [its_pkg::TIME_W-1:0] es [its_pkg::MAX_ENTRIES];
  logic signed [its_pkg::TIME_W-1:0] ee [its_pkg::MAX_ENTRIES];
  logic [its_pkg::TRK_W-1:0]         et [its_pkg::MAX_ENTRIES];

  logic signed [its_pkg::SCALE_W-1:0] scale;
  logic [its_pkg::CNT_W-1:0]          count;
  logic signed [its_pkg::TIME_W-1:0]  ph;
  logic signed [its_pkg::TIME_W-1:0]  old_t;
  logic                               running;
  logic                               paused;
  logic [its_pkg::NUM_TRACKS-1:0]     mask;
  its_pkg::its_req_t                  r;
  logic [1:0]                         st_code;
  logic signed [its_pkg::PROD_W-1:0]  prod;
  logic [its_pkg::CNT_W-1:0]          ptr;
  logic                               dbl;
  its_pkg::its_scan_t                 kind;
  logic                               pend_valid;
  logic [1:0]                         pend_kind;
  logic [3:0]                         pend_idx;

  function automatic logic in_range(input logic signed [its_pkg::TIME_W-1:0] t,
                                    input logic signed [its_pkg::TIME_W-1:0] s,
                                    input logic signed [its_pkg::TIME_W-1:0] e);
    return (t >= s) && (t < e);
  endfunction

  logic [its_pkg::IDX_W-1:0]         a;
  logic signed [its_pkg::TIME_W-1:0] s_rd, e_rd, ns, ne;
  logic [its_pkg::TRK_W-1:0]         t_rd;
  logic                              ena, was, now, skipc, second, has;
  logic                              em_valid;
  logic [1:0]                        em_kind;
  logic signed [its_pkg::SUM_W-1:0]  sum;
  logic signed [its_pkg::TIME_W-1:0] sat;
  logic [its_pkg::CNT_W-1:0]         req_idx;

  assign a    = ptr[its_pkg::IDX_W-1:0];
  assign s_rd = es[a];
  assign e_rd = ee[a];
  assign t_rd = et[a];
  assign ena  = !mask[t_rd];
  assign was  = in_range(old_t, s_rd, e_rd);
  assign now  = in_range(ph, s_rd, e_rd);
  assign skipc = in_range(s_rd, old_t, ph) && in_range(e_rd, old_t, ph);
  assign has  = (count != '0);
  assign second = (kind == its_pkg::SCAN_SKIP) && ena && (was == now) && skipc && !dbl;

  assign sum = its_pkg::SUM_W'(ph) + its_pkg::SUM_W'(prod >>> 8);
  assign sat = (sum > SAT_MAX) ? its_pkg::TIME_W'(SAT_MAX) :
               (sum < SAT_MIN) ? its_pkg::TIME_W'(SAT_MIN) : its_pkg::TIME_W'(sum);

  assign req_idx = its_pkg::CNT_W'(req.entry_index);

  always_comb begin
    ns = s_rd;
    ne = e_rd;
    if (r.mode == its_pkg::MODE_SET_START) ns = r.time_value;
    if (r.mode == its_pkg::MODE_SET_END)   ne = r.end_value;
  end

  // event of this cycle
  always_comb begin
    em_valid = 1'b0;
    em_kind  = its_pkg::EV_NONE;
    if (cmd.op == its_pkg::OP_SCAN && has) begin
      unique case (kind)
        its_pkg::SCAN_START: begin
          em_valid = ena && was;
          em_kind  = its_pkg::EV_START;
        end
        its_pkg::SCAN_STOP: begin
          em_valid = ena && was;
          em_kind  = its_pkg::EV_STOP;
        end
        its_pkg::SCAN_TRACK: begin
          em_valid = (t_rd == r.track_id) && was;
          em_kind  = r.enable ? its_pkg::EV_START : its_pkg::EV_STOP;
        end
        its_pkg::SCAN_MOVE, its_pkg::SCAN_SKIP: begin
          if (ena) begin
            priority if (was && !now) begin
              em_valid = 1'b1;
              em_kind  = its_pkg::EV_STOP;
            end else if (!was && now) begin
              em_valid = 1'b1;
              em_kind  = its_pkg::EV_START;
            end else if (kind == its_pkg::SCAN_SKIP && skipc) begin
              em_valid = 1'b1;
              em_kind  = dbl ? its_pkg::EV_START : its_pkg::EV_STOP;
            end else begin
              em_valid = 1'b0;
            end
          end
        end
        default: em_valid = 1'b0;
      endcase
    end else if (cmd.op == its_pkg::OP_SINGLE && running) begin
      unique case (r.mode)
        its_pkg::MODE_ADD: begin
          em_valid = in_range(ph, r.time_value, r.end_value) && !mask[r.track_id];
          em_kind  = its_pkg::EV_START;
        end
        its_pkg::MODE_REMOVE: begin
          em_valid = ena && in_range(ph, s_rd, e_rd);
          em_kind  = its_pkg::EV_STOP;
        end
        its_pkg::MODE_SET_START, its_pkg::MODE_SET_END: begin
          em_valid = ena && (in_range(ph, s_rd, e_rd) != in_range(ph, ns, ne));
          em_kind  = in_range(ph, ns, ne) ? its_pkg::EV_START : its_pkg::EV_STOP;
        end
        its_pkg::MODE_SET_TRACK: begin
          em_valid = (ena != !mask[r.track_id]) && in_range(ph, s_rd, e_rd);
          em_kind  = !mask[r.track_id] ? its_pkg::EV_START : its_pkg::EV_STOP;
        end
        default: em_valid = 1'b0;
      endcase
    end
  end

  always_comb begin
    stat.mode       = r.mode;
    stat.running    = running;
    stat.paused     = paused;
    stat.idx_bad    = its_pkg::CNT_W'(r.entry_index) >= count;
    stat.full       = (count == its_pkg::CNT_W'(its_pkg::MAX_ENTRIES));
    stat.time_same  = (r.time_value == ph);
    stat.track_noop = (!mask[r.track_id]) == r.enable;
    stat.scan_end   = !has || ((ptr == count - 1'b1) && !second);
    stat.shift_end  = (ptr >= count);
  end

  // entry table
  always_ff @(posedge clk) begin
    if (cmd.op == its_pkg::OP_SINGLE) begin
      unique case (r.mode)
        its_pkg::MODE_ADD: begin
          es[a] <= r.time_value;
          ee[a] <= r.end_value;
          et[a] <= r.track_id;
        end
        its_pkg::MODE_SET_START: es[a] <= r.time_value;
        its_pkg::MODE_SET_END:   ee[a] <= r.end_value;
        its_pkg::MODE_SET_TRACK: et[a] <= r.track_id;
        default: ;
      endcase
    end else if (cmd.op == its_pkg::OP_SHIFT && !stat.shift_end) begin
      es[a - 1'b1] <= s_rd;
      ee[a - 1'b1] <= e_rd;
      et[a - 1'b1] <= t_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == its_pkg::OP_LOAD) r <= req;
    if (cmd.op == its_pkg::OP_MUL) prod <= r.time_value * scale;
    if (em_valid) begin
      pend_kind <= em_kind;
      pend_idx  <= a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale        <= its_pkg::SCALE_RESET;
      count        <= '0;
      ph           <= '0;
      old_t        <= '0;
      running      <= 1'b0;
      paused       <= 1'b0;
      mask         <= '0;
      st_code      <= its_pkg::ST_OK;
      ptr          <= '0;
      dbl          <= 1'b0;
      kind         <= its_pkg::SCAN_MOVE;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) scale <= cfg_data;
      unique case (cmd.op)
        its_pkg::OP_LOAD: begin
          st_code <= (req.mode == its_pkg::MODE_ADD &&
                      count == its_pkg::CNT_W'(its_pkg::MAX_ENTRIES)) ? its_pkg::ST_FULL :
                     ((req.mode == its_pkg::MODE_REMOVE ||
                       req.mode == its_pkg::MODE_SET_START ||
                       req.mode == its_pkg::MODE_SET_END ||
                       req.mode == its_pkg::MODE_SET_TRACK) &&
                      req_idx >= count) ? its_pkg::ST_BAD_INDEX : its_pkg::ST_OK;
          ptr        <= (req.mode == its_pkg::MODE_ADD) ? count : req_idx;
          pend_valid <= 1'b0;
        end
        its_pkg::OP_MODE: paused <= (r.mode == its_pkg::MODE_PAUSE);
        its_pkg::OP_SAT: begin
          old_t <= ph;
          ph    <= sat;
          kind  <= its_pkg::SCAN_SKIP;
          ptr   <= '0;
          dbl   <= 1'b0;
        end
        its_pkg::OP_PREP_SET: begin
          old_t <= ph;
          ph    <= r.time_value;
          kind  <= its_pkg::SCAN_MOVE;
          ptr   <= '0;
          dbl   <= 1'b0;
        end
        its_pkg::OP_PREP_STOP: begin
          old_t   <= ph;
          ph      <= '0;
          running <= 1'b0;
          kind    <= its_pkg::SCAN_STOP;
          ptr     <= '0;
        end
        its_pkg::OP_PREP_START: begin
          old_t   <= ph;
          running <= 1'b1;
          kind    <= its_pkg::SCAN_START;
          ptr     <= '0;
        end
        its_pkg::OP_PREP_TRACK: begin
          mask[r.track_id] <= !r.enable;
          old_t <= ph;
          kind  <= its_pkg::SCAN_TRACK;
          ptr   <= '0;
        end
        its_pkg::OP_SINGLE: begin
          if (r.mode == its_pkg::MODE_ADD) count <= count + 1'b1;
          if (r.mode == its_pkg::MODE_REMOVE) ptr <= ptr + 1'b1;
        end
        its_pkg::OP_SCAN: begin
          if (second) begin
            dbl <= 1'b1;
          end else begin
            dbl <= 1'b0;
            ptr <= ptr + 1'b1;
          end
        end
        its_pkg::OP_SHIFT: begin
          if (stat.shift_end) count <= count - 1'b1;
          else ptr <= ptr + 1'b1;
        end
        default: ;
      endcase

      if (cmd.op == its_pkg::OP_FLUSH) begin
        result_valid       <= 1'b1;
        result.event_kind  <= pend_valid ? pend_kind : its_pkg::EV_NONE;
        result.event_index <= pend_valid ? pend_idx : 4'd0;
        result.status      <= st_code;
        result.playhead    <= ph;
        result.last        <= 1'b1;
        pend_valid         <= 1'b0;
      end else if (em_valid) begin
        pend_valid   <= 1'b1;
        result_valid <= pend_valid;
        if (pend_valid) begin
          result.event_kind  <= pend_kind;
          result.event_index <= pend_idx;
          result.status      <= st_code;
          result.playhead    <= ph;
          result.last        <= 1'b0;
        end
      end else begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// File: design/interval_timeline_sequencer.sv
`timescale 1ns / 1ps
// Channel  | Ports                      | Handshake
// request  | start, busy, req           | taken when start && !busy
// config   | cfg_we, cfg_data           | written when cfg_we
// result   | result_valid, result       | one cycle per strobe, no backpressure
//
// busy is high for decode and flush plus the work: a scan visits each entry in turn (an empty
// table still takes a scan step), and visits once more an entry that a tick skips over; a tick
// adds the scale multiply and saturation states; start while running scans twice with a restart
// state between; remove shifts down each entry above the removed one.
// rst is synchronous and clears control state; the entry table is not cleared.
// Results cannot be stalled; the final result of a request shows with busy already low.
module interval_timeline_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  its_pkg::its_req_t                  req,
  input  logic                               cfg_we,
  input  logic signed [its_pkg::SCALE_W-1:0] cfg_data,
  output logic                               result_valid,
  output its_pkg::its_result_t               result
);

  its_pkg::its_cmd_t  cmd;
  its_pkg::its_stat_t stat;

  its_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  its_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// File: design/its_checker.sv
`timescale 1ns / 1ps
`include "interval_timeline_sequencer_defines.svh"
module its_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 result_valid,
  input its_pkg::its_result_t result
);

  `ITS_ASSERT_NEXT(a_req_busy, start && !busy, busy, "request not taken")
  `ITS_ASSERT_NEXT(a_last_gap, result_valid && result.last, !result_valid, "result after last")
  `ITS_ASSERT_NOW(a_none_last, result_valid && result.event_kind == its_pkg::EV_NONE, result.last, "empty result not last")
  `ITS_ASSERT_NOW(a_done_last, $fell(busy), result_valid && result.last, "request ended without last")

endmodule

bind interval_timeline_sequencer its_checker u_its_checker (.*);

// File: sim/its_checker.sv
`timescale 1ns / 1ps
module its_scoreboard (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  its_pkg::its_req_t                  req,
  input  logic                               cfg_we,
  input  logic signed [its_pkg::SCALE_W-1:0] cfg_data,
  input  logic                               result_valid,
  input  its_pkg::its_result_t               result,
  output int                                 fail_count,
  output int                                 pending
);

  logic signed [31:0]   ent_start [its_pkg::MAX_ENTRIES];
  logic signed [31:0]   ent_end [its_pkg::MAX_ENTRIES];
  logic [4:0]           ent_track [its_pkg::MAX_ENTRIES];
  int                   ent_count;
  logic signed [31:0]   head;
  logic                 running, paused;
  logic [31:0]          disabled;
  logic signed [15:0]   scale;
  its_pkg::its_result_t expected_q[$];
  logic [1:0]           ev_kind[$];
  logic [3:0]           ev_idx[$];

  function automatic bit inside_iv(logic signed [31:0] t, logic signed [31:0] s,
                                   logic signed [31:0] e);
    return t >= s && t < e;
  endfunction

  function automatic bit trk_on(logic [4:0] t);
    return !disabled[t];
  endfunction

  task automatic note(logic [1:0] k, int i);
    ev_kind = {ev_kind, k};
    ev_idx = {ev_idx, i[3:0]};
  endtask

  task automatic announce_live(logic [1:0] k);
    for (int i = 0; i < ent_count; i++)
      if (trk_on(ent_track[i]) && inside_iv(head, ent_start[i], ent_end[i])) note(k, i);
  endtask

  task automatic halt();
    if (running) begin
      announce_live(its_pkg::EV_STOP);
      running = 0;
      head = 0;
    end
  endtask

  task automatic seek(logic signed [31:0] nt, bit skip);
    logic signed [31:0] old;
    bit was, now;
    old = head;
    head = nt;
    for (int i = 0; i < ent_count; i++) begin
      if (!trk_on(ent_track[i])) continue;
      was = inside_iv(old, ent_start[i], ent_end[i]);
      now = inside_iv(nt, ent_start[i], ent_end[i]);
      if (was && !now) note(its_pkg::EV_STOP, i);
      else if (!was && now) note(its_pkg::EV_START, i);
      else if (skip && inside_iv(ent_start[i], old, nt) && inside_iv(ent_end[i], old, nt)) begin
        note(its_pkg::EV_STOP, i);
        note(its_pkg::EV_START, i);
      end
    end
  endtask

  task automatic reshape(int i, logic signed [31:0] s, logic signed [31:0] e);
    bit was, now;
    if (running && trk_on(ent_track[i])) begin
      was = inside_iv(head, ent_start[i], ent_end[i]);
      now = inside_iv(head, s, e);
      if (was && !now) note(its_pkg::EV_STOP, i);
      else if (!was && now) note(its_pkg::EV_START, i);
    end
    ent_start[i] = s;
    ent_end[i] = e;
  endtask

  task automatic sequence_step(its_pkg::its_req_t r);
    logic [1:0]           st;
    longint               prod, dt, sum;
    int                   idx;
    bit                   was, now;
    its_pkg::its_result_t res;
    st = its_pkg::ST_OK;
    idx = r.entry_index;
    ev_kind.delete();
    ev_idx.delete();
    case (r.mode)
      its_pkg::MODE_TICK: if (running && !paused) begin
        prod = longint'(r.time_value) * longint'(scale);
        dt = prod >>> 8;
        sum = longint'(head) + dt;
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        seek(sum[31:0], 1);
      end
      its_pkg::MODE_SET_TIME: if (running && r.time_value != head) seek(r.time_value, 0);
      its_pkg::MODE_START: begin
        halt();
        running = 1;
        announce_live(its_pkg::EV_START);
      end
      its_pkg::MODE_STOP: halt();
      its_pkg::MODE_PAUSE: paused = 1;
      its_pkg::MODE_RESUME: paused = 0;
      its_pkg::MODE_ADD: begin
        if (ent_count >= its_pkg::MAX_ENTRIES) st = its_pkg::ST_FULL;
        else begin
          ent_start[ent_count] = r.time_value;
          ent_end[ent_count] = r.end_value;
          ent_track[ent_count] = r.track_id;
          if (running && inside_iv(head, r.time_value, r.end_value) && trk_on(r.track_id))
            note(its_pkg::EV_START, ent_count);
          ent_count++;
        end
      end
      its_pkg::MODE_REMOVE: begin
        if (idx >= ent_count) st = its_pkg::ST_BAD_INDEX;
        else begin
          if (running && trk_on(ent_track[idx]) &&
              inside_iv(head, ent_start[idx], ent_end[idx])) note(its_pkg::EV_STOP, idx);
          for (int i = idx; i + 1 < ent_count; i++) begin
            ent_start[i] = ent_start[i+1];
            ent_end[i] = ent_end[i+1];
            ent_track[i] = ent_track[i+1];
          end
          ent_count--;
        end
      end
      its_pkg::MODE_SET_START: if (idx >= ent_count) st = its_pkg::ST_BAD_INDEX;
        else reshape(idx, r.time_value, ent_end[idx]);
      its_pkg::MODE_SET_END: if (idx >= ent_count) st = its_pkg::ST_BAD_INDEX;
        else reshape(idx, ent_start[idx], r.end_value);
      its_pkg::MODE_SET_TRACK: begin
        if (idx >= ent_count) st = its_pkg::ST_BAD_INDEX;
        else begin
          was = trk_on(ent_track[idx]);
          ent_track[idx] = r.track_id;
          now = trk_on(ent_track[idx]);
          if (running && was != now && inside_iv(head, ent_start[idx], ent_end[idx]))
            note(now ? its_pkg::EV_START : its_pkg::EV_STOP, idx);
        end
      end
      its_pkg::MODE_ENABLE_TRACK: if (trk_on(r.track_id) != r.enable) begin
        disabled[r.track_id] = !r.enable;
        if (running)
          for (int i = 0; i < ent_count; i++)
            if (ent_track[i] == r.track_id && inside_iv(head, ent_start[i], ent_end[i]))
              note(r.enable ? its_pkg::EV_START : its_pkg::EV_STOP, i);
      end
      default: ;
    endcase
    if (ev_kind.size() == 0) note(its_pkg::EV_NONE, 0);
    for (int k = 0; k < ev_kind.size(); k++) begin
      res.event_kind = ev_kind[k];
      res.event_index = ev_idx[k];
      res.status = st;
      res.playhead = head;
      res.last = (k == ev_kind.size() - 1);
      expected_q = {expected_q, res};
    end
  endtask

  always @(posedge clk) begin
    its_pkg::its_result_t want;
    if (rst) begin
      ent_count = 0;
      head = 0;
      running = 0;
      paused = 0;
      disabled = '0;
      scale = its_pkg::SCALE_RESET;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (result_valid) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result %p", result);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (result !== want) begin
            fail_count <= fail_count + 1;
            if (result.event_kind !== want.event_kind)
              $error("event_kind exp %0d got %0d", want.event_kind, result.event_kind);
            if (result.event_index !== want.event_index)
              $error("event_index exp %0d got %0d", want.event_index, result.event_index);
            if (result.status !== want.status)
              $error("status exp %0d got %0d", want.status, result.status);
            if (result.playhead !== want.playhead)
              $error("playhead exp %0d got %0d", want.playhead, result.playhead);
            if (result.last !== want.last)
              $error("last exp %0d got %0d", want.last, result.last);
          end
        end
      end
      if (cfg_we) scale = cfg_data;
      if (start && !busy) sequence_step(req);
    end
    pending <= expected_q.size();
  end
endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;

  logic                 clk, rst, start, busy, cfg_we, result_valid;
  logic signed [15:0]   cfg_data;
  its_pkg::its_req_t    req;
  its_pkg::its_result_t result;
  int                   fail_count, pending;
  int                   gap_pct;
  int                   live;
  logic signed [31:0]   anchor;

  interval_timeline_sequencer dut (.*);
  its_scoreboard chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("interval_timeline_sequencer test failed");
    $finish;
  end

  task automatic issue(its_pkg::its_req_t r);
    while ($urandom_range(99) < gap_pct) @(posedge clk);
    start <= 1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 0;
    @(posedge clk);
    case (r.mode)
      its_pkg::MODE_ADD: if (live < its_pkg::MAX_ENTRIES) live++;
      its_pkg::MODE_REMOVE: if (r.entry_index < live) live--;
      its_pkg::MODE_STOP: anchor = 0;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_scale(logic signed [15:0] v);
    drain();
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic its_pkg::its_req_t mk(logic [3:0] m, logic signed [31:0] tv,
                                           logic signed [31:0] ev, logic [3:0] ix,
                                           logic [4:0] tr, logic en);
    its_pkg::its_req_t r;
    r.mode = m;
    r.time_value = tv;
    r.end_value = ev;
    r.entry_index = ix;
    r.track_id = tr;
    r.enable = en;
    return r;
  endfunction

  function automatic logic signed [31:0] near_time();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return anchor + $signed($urandom_range(2000)) - 1000;
    endcase
  endfunction

  function automatic its_pkg::its_req_t rand_req();
    logic [3:0]         m;
    logic signed [31:0] s;
    m = $urandom_range(99) < 3 ? 4'($urandom_range(15)) : 4'($urandom_range(11));
    if (m == its_pkg::MODE_STOP && $urandom_range(3) != 0) m = its_pkg::MODE_TICK;
    s = near_time();
    return mk(m, (m == its_pkg::MODE_TICK && $urandom_range(3) != 0) ?
                  $signed($urandom_range(600)) - 200 : s,
              $urandom_range(4) == 0 ? $signed($urandom) : s + $urandom_range(1500),
              $urandom_range(4) == 0 ? 4'($urandom) : 4'($urandom_range(live > 0 ? live-1 : 0)),
              $urandom_range(3) == 0 ? 5'($urandom) : 5'($urandom_range(3)),
              $urandom_range(1));
  endfunction

  initial begin
    rst = 1;
    start = 0;
    cfg_we = 0;
    cfg_data = 0;
    req = '0;
    gap_pct = 34;
    live = 0;
    anchor = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    issue(mk(its_pkg::MODE_TICK, 100, 0, 0, 0, 0));
    issue(mk(its_pkg::MODE_REMOVE, 0, 0, 0, 0, 0));
    issue(mk(its_pkg::MODE_ADD, 0, 32'sh7fffffff, 0, 0, 0));
    issue(mk(its_pkg::MODE_ADD, 32'sh80000000, 10, 0, 31, 0));
    issue(mk(its_pkg::MODE_ADD, 50, 60, 0, 2, 1));
    issue(mk(its_pkg::MODE_START, 0, 0, 0, 0, 0));
    issue(mk(its_pkg::MODE_TICK, 200, 0, 0, 0, 0));
    issue(mk(its_pkg::MODE_PAUSE, 0, 0, 0, 0, 0));
    issue(mk(its_pkg::MODE_TICK, 5, 0, 0, 0, 0));
    issue(mk(its_pkg::MODE_RESUME, 0, 0, 0, 0, 0));
    issue(mk(its_pkg::MODE_SET_TIME, 32'sh7fffffff, 0, 0, 0, 0));
    issue(mk(its_pkg::MODE_TICK, 32'sh7fffffff, 0, 0, 0, 0));
    issue(mk(its_pkg::MODE_SET_TIME, 20, 0, 0, 0, 0));
    issue(mk(its_pkg::MODE_ENABLE_TRACK, 0, 0, 0, 0, 0));
    issue(mk(its_pkg::MODE_ENABLE_TRACK, 0, 0, 0, 0, 0));
    issue(mk(its_pkg::MODE_ENABLE_TRACK, 0, 0, 0, 0, 1));
    issue(mk(its_pkg::MODE_SET_TRACK, 0, 0, 0, 31, 0));
    issue(mk(its_pkg::MODE_SET_START, 30, 0, 0, 0, 0));
    issue(mk(its_pkg::MODE_SET_END, 0, 25, 1, 0, 0));
    issue(mk(its_pkg::MODE_SET_START, 0, 0, 15, 0, 0));
    issue(mk(its_pkg::MODE_TICK, 32'sh80000000, 0, 0, 0, 0));
    issue(mk(4'd15, 32'shffffffff, 32'shffffffff, 15, 31, 1));
    issue(mk(its_pkg::MODE_REMOVE, 0, 0, 0, 0, 0));
    issue(mk(its_pkg::MODE_STOP, 0, 0, 0, 0, 0));
    for (int i = 0; i < 15; i++) issue(mk(its_pkg::MODE_ADD, i, i + 100, 0, 5'(i), 0));
    issue(mk(its_pkg::MODE_ADD, 0, 1, 0, 0, 0));

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_scale(16'sh7fff);
        1: set_scale(16'sh8000);
        2: set_scale(-16'sd256);
        3: set_scale(16'sd1);
        4: set_scale(its_pkg::SCALE_RESET);
      endcase
      gap_pct = ph < 2 ? 34 : (ph < 4 ? 62 : 0);
      issue(mk(its_pkg::MODE_START, 0, 0, 0, 0, 0));
      for (int n = 0; n < 88; n++) begin
        issue(rand_req());
        if (n == 40) drain();
      end
    end
    drain();
    if (fail_count == 0) $display("interval_timeline_sequencer test passed");
    else $display("interval_timeline_sequencer test failed");
    $finish;
  end
endmodule
